// ===== rtl/matrix_inverse_4x4_top_assert.svh =====
// assertion macros for the matrix inverse checker
// needs clk and arst_n in the scope where a macro is used
`ifndef MATRIX_INVERSE_4X4_TOP_ASSERT_SVH
`define MATRIX_INVERSE_4X4_TOP_ASSERT_SVH

// same-cycle implication
`define MI4_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MI4_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mi4_pkg.sv =====
// shared constants and index helpers for the 4x4 matrix inverse
// no dependencies
`default_nettype none
package mi4_pkg;
	localparam int ELEMENT_WIDTH_DEF = 32;
	localparam int FRAC_BITS = 16;
	localparam int RECIP_BITS = 62;
	localparam int COF_W = 64;

	// m-th index of 0..3 that skips excl
	function automatic logic [1:0] skip_idx(input logic [1:0] excl, input logic [1:0] m);
		skip_idx = (m < excl) ? m : 2'(m + 2'd1);
	endfunction

	// column slot of each permutation of three
	function automatic logic [1:0] perm_sel(input logic [2:0] p, input logic [1:0] slot);
		logic [5:0] row;
		begin
			case (p)
				3'd0: row = {2'd2, 2'd1, 2'd0};
				3'd1: row = {2'd1, 2'd2, 2'd0};
				3'd2: row = {2'd2, 2'd0, 2'd1};
				3'd3: row = {2'd0, 2'd2, 2'd1};
				3'd4: row = {2'd1, 2'd0, 2'd2};
				default: row = {2'd0, 2'd1, 2'd2};
			endcase
			case (slot)
				2'd0: perm_sel = row[1:0];
				2'd1: perm_sel = row[3:2];
				default: perm_sel = row[5:4];
			endcase
		end
	endfunction

	function automatic logic perm_odd(input logic [2:0] p);
		perm_odd = (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
	endfunction
endpackage
`default_nettype wire

// ===== rtl/matrix_inverse_4x4_top.sv =====
// 4x4 matrix inverse: loads 16 items, one per cycle while start is high, then computes and
// emits 16 results. the time from the 16th item to the last result is data dependent,
// dominated by the shared shift-add multiplier retiring one multiplier bit per cycle; a zero
// determinant skips the reciprocal and emits 16 back to back results. a new matrix is
// taken only once busy drops with the last result; the receiver cannot stall.
// reset clears the load count, the sequencer state and the output strobes.
`default_nettype none
module matrix_inverse_4x4_top #(
	parameter int ELEMENT_WIDTH = mi4_pkg::ELEMENT_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [ELEMENT_WIDTH-1:0] element,
	output logic                          busy,
	output logic                          valid,
	output logic [ELEMENT_WIDTH-1:0]      inverse_element,
	output logic                          singular,
	output logic                          last
);
	localparam int W = ELEMENT_WIDTH;
	localparam int AW = 3 * W + 84;
	localparam int NW = $clog2(AW + 1);
	localparam int CW = mi4_pkg::COF_W;
	localparam int RS = mi4_pkg::RECIP_BITS - 2 * mi4_pkg::FRAC_BITS;

	typedef enum logic [4:0] {
		S_LOAD, S_CF_A, S_CF_B, S_CF_M1, S_CF_C, S_CF_M2, S_CF_DONE,
		S_DT_A, S_DT_M, S_CHK, S_SCAN, S_DIV,
		S_IV_A, S_IV_M, S_IV_SH, S_IV_OUT, S_ID_OUT
	} state_t;

	state_t state_q;
	logic [3:0] ld_cnt_q, ci_q;
	logic [2:0] p_q;
	logic [5:0] it_q;
	logic [W-1:0] src_q [16];
	logic [CW-1:0] cof_q [16];
	logic [W-1:0] a_q;
	logic sgn_q, dneg_q;
	logic [AW-1:0] acc_q, det_q, d_q, x_q, pw_q, rem_q, q_q;
	logic [CW-1:0] r_q;
	logic [NW-1:0] n_q, sh_q;
	logic mstart_q;
	logic [AW-1:0] ma_q;
	logic [CW-1:0] mb_q;
	logic valid_q, sing_q, last_q;
	logic [W-1:0] out_q;

	logic mul_done;
	logic [AW-1:0] mul_prod;

	mi4_mul #(.AW(AW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mstart_q), .a(ma_q), .b(mb_q),
		.done(mul_done), .prod(mul_prod)
	);

	// operand fetch
	logic [1:0] slot;
	logic [3:0] rd_addr, cof_addr;
	logic [W-1:0] e_rd, e_mag;
	logic e_neg;
	logic [CW-1:0] c_rd, c_mag;
	logic c_neg;

	always_comb begin
		case (state_q)
			S_CF_A: slot = 2'd0;
			S_CF_B: slot = 2'd1;
			default: slot = 2'd2;
		endcase
		if (state_q == S_DT_A) begin
			rd_addr = {2'b00, ci_q[1:0]};
			cof_addr = {ci_q[1:0], 2'b00};
		end else begin
			rd_addr = {mi4_pkg::skip_idx(ci_q[1:0], slot),
				mi4_pkg::skip_idx(ci_q[3:2], mi4_pkg::perm_sel(p_q, slot))};
			cof_addr = ci_q;
		end
	end

	assign e_rd = src_q[rd_addr];
	assign e_neg = e_rd[W-1];
	assign e_mag = e_neg ? (~e_rd + W'(1)) : e_rd;
	assign c_rd = cof_q[cof_addr];
	assign c_neg = c_rd[CW-1];
	assign c_mag = c_neg ? (~c_rd + CW'(1)) : c_rd;

	// signed product and cofactor finish
	logic [AW-1:0] prod_s, cf_v, cf_sh, det_mag, rnd;
	logic [CW-1:0] cf_sat;
	logic cf_hi_ones, cf_hi_zero;

	assign prod_s = sgn_q ? (~mul_prod + AW'(1)) : mul_prod;
	assign cf_v = (ci_q[2] ^ ci_q[0]) ? (~acc_q + AW'(1)) : acc_q;
	assign cf_sh = AW'($signed(cf_v) >>> (2 * mi4_pkg::FRAC_BITS));
	assign cf_hi_ones = &cf_sh[AW-1:CW-1];
	assign cf_hi_zero = ~|cf_sh[AW-1:CW-1];
	assign cf_sat = (cf_hi_ones || cf_hi_zero) ? cf_sh[CW-1:0]
		: (cf_sh[AW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});
	assign det_mag = det_q[AW-1] ? (~det_q + AW'(1)) : det_q;
	assign rnd = (mul_prod + (pw_q << RS)) >> RS;

	// saturate the magnitude with its sign to W bits
	logic [AW-1:0] lim;
	logic [W-1:0] min_w, max_w, inv_val, one_w;
	logic [W:0] one_ext;

	assign lim = AW'(1) << (W - 1);
	assign min_w = {1'b1, {(W-1){1'b0}}};
	assign max_w = {1'b0, {(W-1){1'b1}}};
	assign one_ext = (W+1)'(1) << mi4_pkg::FRAC_BITS;
	assign one_w = one_ext[W-1:0];

	always_comb begin
		if (sgn_q) begin
			inv_val = (q_q > lim) ? min_w : (~q_q[W-1:0] + W'(1));
		end else begin
			inv_val = (q_q >= lim) ? max_w : q_q[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			ld_cnt_q <= '0;
			mstart_q <= 1'b0;
			valid_q <= 1'b0;
			sing_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			mstart_q <= 1'b0;
			valid_q <= 1'b0;
			unique case (state_q)
				S_LOAD: begin
					if (start) begin
						src_q[ld_cnt_q] <= element;
						ld_cnt_q <= ld_cnt_q + 4'd1;
						if (ld_cnt_q == 4'd15) begin
							ci_q <= '0;
							p_q <= '0;
							acc_q <= '0;
							state_q <= S_CF_A;
						end
					end
				end
				S_CF_A: begin
					a_q <= e_mag;
					sgn_q <= e_neg;
					state_q <= S_CF_B;
				end
				S_CF_B: begin
					ma_q <= AW'(a_q);
					mb_q <= CW'(e_mag);
					sgn_q <= sgn_q ^ e_neg;
					mstart_q <= 1'b1;
					state_q <= S_CF_M1;
				end
				S_CF_M1: begin
					if (mul_done) begin
						state_q <= S_CF_C;
					end
				end
				S_CF_C: begin
					ma_q <= mul_prod;
					mb_q <= CW'(e_mag);
					sgn_q <= sgn_q ^ e_neg ^ mi4_pkg::perm_odd(p_q);
					mstart_q <= 1'b1;
					state_q <= S_CF_M2;
				end
				S_CF_M2: begin
					if (mul_done) begin
						acc_q <= acc_q + prod_s;
						if (p_q == 3'd5) begin
							state_q <= S_CF_DONE;
						end else begin
							p_q <= p_q + 3'd1;
							state_q <= S_CF_A;
						end
					end
				end
				S_CF_DONE: begin
					cof_q[ci_q] <= cf_sat;
					acc_q <= '0;
					p_q <= '0;
					ci_q <= ci_q + 4'd1;
					if (ci_q == 4'd15) begin
						det_q <= '0;
						state_q <= S_DT_A;
					end else begin
						state_q <= S_CF_A;
					end
				end
				S_DT_A: begin
					ma_q <= AW'(e_mag);
					mb_q <= c_mag;
					sgn_q <= e_neg ^ c_neg;
					mstart_q <= 1'b1;
					state_q <= S_DT_M;
				end
				S_DT_M: begin
					if (mul_done) begin
						det_q <= det_q + prod_s;
						if (ci_q[1:0] == 2'd3) begin
							ci_q <= '0;
							state_q <= S_CHK;
						end else begin
							ci_q <= ci_q + 4'd1;
							state_q <= S_DT_A;
						end
					end
				end
				S_CHK: begin
					if (det_q == '0) begin
						state_q <= S_ID_OUT;
					end else begin
						dneg_q <= det_q[AW-1];
						d_q <= det_mag;
						x_q <= det_mag;
						pw_q <= AW'(1);
						n_q <= NW'(1);
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// pw ends at the top set bit of |det|, n at its bit length
					if ((x_q >> 1) != '0) begin
						x_q <= x_q >> 1;
						pw_q <= pw_q << 1;
						n_q <= n_q + NW'(1);
					end else begin
						rem_q <= pw_q;
						r_q <= '0;
						it_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (rem_q >= d_q) begin
						rem_q <= (rem_q - d_q) << 1;
						r_q <= {r_q[CW-2:0], 1'b1};
					end else begin
						rem_q <= rem_q << 1;
						r_q <= {r_q[CW-2:0], 1'b0};
					end
					it_q <= it_q + 6'd1;
					if (it_q == 6'd63) begin
						ci_q <= '0;
						state_q <= S_IV_A;
					end
				end
				S_IV_A: begin
					ma_q <= AW'(c_mag);
					mb_q <= r_q;
					sgn_q <= c_neg ^ dneg_q;
					mstart_q <= 1'b1;
					state_q <= S_IV_M;
				end
				S_IV_M: begin
					if (mul_done) begin
						q_q <= rnd;
						sh_q <= n_q;
						state_q <= S_IV_SH;
					end
				end
				S_IV_SH: begin
					if (sh_q == '0) begin
						state_q <= S_IV_OUT;
					end else begin
						q_q <= q_q >> 1;
						sh_q <= sh_q - NW'(1);
					end
				end
				S_IV_OUT: begin
					valid_q <= 1'b1;
					out_q <= inv_val;
					sing_q <= 1'b0;
					last_q <= (ci_q == 4'd15);
					ci_q <= ci_q + 4'd1;
					state_q <= (ci_q == 4'd15) ? S_LOAD : S_IV_A;
				end
				S_ID_OUT: begin
					valid_q <= 1'b1;
					out_q <= (ci_q[3:2] == ci_q[1:0]) ? one_w : '0;
					sing_q <= 1'b1;
					last_q <= (ci_q == 4'd15);
					ci_q <= ci_q + 4'd1;
					if (ci_q == 4'd15) begin
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign busy = (state_q != S_LOAD);
	assign valid = valid_q;
	assign inverse_element = out_q;
	assign singular = sing_q & valid_q;
	assign last = last_q & valid_q;
endmodule
`default_nettype wire

// ===== rtl/mi4_mul.sv =====
// shift-add unsigned multiplier, one multiplier bit per cycle
// depends on mi4_pkg for the multiplier operand width
`default_nettype none
module mi4_mul #(
	parameter int AW = 3 * mi4_pkg::ELEMENT_WIDTH_DEF + 84
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [AW-1:0]             a,
	input  wire logic [mi4_pkg::COF_W-1:0] b,
	output logic                           done,
	output logic [AW-1:0]                  prod
);
	logic run_q, done_q;
	logic [AW-1:0] a_q, acc_q;
	logic [mi4_pkg::COF_W-1:0] b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && b_q == '0) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (run_q && b_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

// ===== rtl/mi4_checker.sv =====
// port-level checks on the result strobe of the matrix inverse
// depends on matrix_inverse_4x4_top_assert.svh; bound to matrix_inverse_4x4_top
`default_nettype none
`include "matrix_inverse_4x4_top_assert.svh"
module mi4_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic busy,
	input wire logic valid,
	input wire logic singular,
	input wire logic last
);
	`MI4_ASSERT_IMP(a_last_strobe, last, valid, "last without a result strobe")
	`MI4_ASSERT_IMP(a_busy_mid, valid && !last, busy, "idle before the final item")
	`MI4_ASSERT_NXT(a_ident_run, valid && singular && !last, valid && singular,
		"identity items not back to back")
	`MI4_ASSERT_NXT(a_after_last, last, !valid && !busy, "activity after the final item")
endmodule

bind matrix_inverse_4x4_top mi4_checker u_mi4_checker (
	.clk(clk), .arst_n(arst_n), .busy(busy), .valid(valid),
	.singular(singular), .last(last)
);
`default_nettype wire
